@@ hdl/bce_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and curve constants for the battery charge estimator.
// No dependencies; imported by the top, bce_ctrl, bce_dp and the bench.
package bce_pkg;

  // Field widths
  localparam int VOLT_W     = 15;
  localparam int CUR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int PCT_W      = 10;
  localparam int REST_CUR_W = 15;

  // Stream bus widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_CURRENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_TIME    = 1'b1;
  localparam logic [REST_CUR_W-1:0] REST_CUR_RST    = 15'd50;
  localparam logic [TIME_W-1:0]     REST_TIME_RST   = 32'd30000;

  // Moving average depth default
  localparam int AVG_DEPTH_DEF = 20;

  // Discharge curve of a 3S pack
  localparam int CURVE_PTS = 12;
  localparam int SEG_W     = 4;
  localparam int MV_W      = 14;
  localparam int SPAN_W    = 10;
  localparam int STEP_W    = 7;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(CURVE_PTS - 1);

  // Quotient of the interpolation stays below 100
  localparam int QUO_W  = 7;
  localparam int QCNT_W = 3;
  localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QUO_W - 1);

  // One curve point: its voltage, the span to the point above, the
  // percent step to it (in tenths) and its own charge in tenths.
  typedef struct packed {
    logic [MV_W-1:0]   mv;
    logic [SPAN_W-1:0] span;
    logic [STEP_W-1:0] step10;
    logic [PCT_W-1:0]  base10;
  } curve_pt_t;

  localparam curve_pt_t CURVE [CURVE_PTS] = '{
    '{14'd12600, 10'd0,   7'd0,   10'd1000},
    '{14'd12450, 10'd150, 7'd50,  10'd950},
    '{14'd12350, 10'd100, 7'd50,  10'd900},
    '{14'd12250, 10'd100, 7'd100, 10'd800},
    '{14'd12150, 10'd100, 7'd100, 10'd700},
    '{14'd12050, 10'd100, 7'd100, 10'd600},
    '{14'd11950, 10'd100, 7'd100, 10'd500},
    '{14'd11850, 10'd100, 7'd100, 10'd400},
    '{14'd11750, 10'd100, 7'd100, 10'd300},
    '{14'd11600, 10'd150, 7'd100, 10'd200},
    '{14'd11400, 10'd200, 7'd100, 10'd100},
    '{14'd10500, 10'd900, 7'd100, 10'd0}
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic ring_rd;
    logic accum;
    logic cmp;
    logic mul_num;
    logic mul_den;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic seg_first;
    logic seg_last;
    logic div_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ hdl/battery_charge_estimator_top.sv @@
`timescale 1ns / 1ps
// Top level of the battery charge estimator: stream ports, packing and
// configuration port. Depends on bce_pkg, bce_ctrl, bce_dp and bce_ram.
//
// Usage:
// - Input stream s_axis: one item per voltage/current/timestamp sample.
// - Output stream m_axis: one result item per input item, in order, with
//   the raw and rest-latched charge in tenths of a percent.
// - Configuration: cfg_we_i writes cfg_data_i into the register selected by
//   cfg_idx_i (rest current threshold, rest time); write only while idle.
// - Sequence: the sample is read from the ring and summed, the 12-point curve
//   is walked down from the top one point per cycle until the average clears
//   a point (top point: 100.0 percent; no point cleared: 0), else a 7-step
//   restoring divider gives the interpolation quotient.
// - One item in flight: s_axis_tready_o returns in the same cycle as the
//   result enters the output register; no new sample is taken before then.
// - Reset clears the ring fill, the running sum, the rest tracker and the
//   latch; both registers return to 50 mA and 30000 ms.
// - A stalled receiver holds the result in the output register; the next
//   item is taken and computed meanwhile, and waits to load until it frees.
module battery_charge_estimator_top #(
  parameter int AVG_DEPTH = bce_pkg::AVG_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // [14:0] voltage_sample_mv, [30:15] current_sample_ma, [62:31] time_now_ms
  input  logic [bce_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [14:0] voltage_out_mv, [30:15] current_out_ma, [40:31] percent_raw_tenths,
  // [50:41] percent_stable_tenths
  output logic [bce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [0] stable_valid
  output logic [bce_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bce_pkg::*;

  localparam int OUT_PAD = OUT_TDATA_W - (VOLT_W + CUR_W + 2 * PCT_W);

  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;
  logic [VOLT_W-1:0] out_volt;
  logic [CUR_W-1:0]  out_cur;
  logic [PCT_W-1:0]  out_raw;
  logic [PCT_W-1:0]  out_stable;
  logic              out_svld;

  // Sequencer
  bce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath
  bce_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_volt_i        (s_axis_tdata_i[VOLT_W-1:0]),
    .in_cur_i         (s_axis_tdata_i[VOLT_W +: CUR_W]),
    .in_time_i        (s_axis_tdata_i[VOLT_W + CUR_W +: TIME_W]),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_volt_o       (out_volt),
    .out_cur_o        (out_cur),
    .out_raw_o        (out_raw),
    .out_stable_o     (out_stable),
    .out_stable_vld_o (out_svld)
  );

  // Output packing, first field in the low bits
  assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, out_stable, out_raw, out_cur, out_volt};
  assign m_axis_tuser_o = out_svld;

endmodule

@@ hdl/bce_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bce_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bce_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the charge estimator: walks one item through ring update,
// curve search, divide and output load. Depends on bce_pkg.
module bce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  bce_pkg::ctrl_sts_t    sts_i,
  output bce_pkg::ctrl_cmd_t    cmd_o
);
  import bce_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_ACCUM = 8'b0000_0100,
    ST_CMP   = 8'b0000_1000,
    ST_MULN  = 8'b0001_0000,
    ST_MULD  = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.ring_rd = 1'b1;
        state_d       = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.hit) begin
          state_d = sts_i.seg_first ? ST_OUT : ST_MULN;
        end else if (sts_i.seg_last) begin
          state_d = ST_OUT;
        end
      end
      ST_MULN: begin
        cmd_o.mul_num = 1'b1;
        state_d       = ST_MULD;
      end
      ST_MULD: begin
        cmd_o.mul_den = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/bce_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the charge estimator: sample ring, running sum, curve search,
// interpolation divider, rest latch and output register. Depends on bce_pkg
// and bce_ram.
module bce_dp #(
  parameter int AVG_DEPTH = bce_pkg::AVG_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bce_pkg::ctrl_cmd_t               cmd_i,
  output bce_pkg::ctrl_sts_t               sts_o,
  input  logic [bce_pkg::VOLT_W-1:0]       in_volt_i,
  input  logic [bce_pkg::CUR_W-1:0]        in_cur_i,
  input  logic [bce_pkg::TIME_W-1:0]       in_time_i,
  input  logic                             cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [bce_pkg::VOLT_W-1:0]       out_volt_o,
  output logic [bce_pkg::CUR_W-1:0]        out_cur_o,
  output logic [bce_pkg::PCT_W-1:0]        out_raw_o,
  output logic [bce_pkg::PCT_W-1:0]        out_stable_o,
  output logic                             out_stable_vld_o
);
  import bce_pkg::*;

  localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = VOLT_W + $clog2(AVG_DEPTH);
  localparam int PROD_W = CNT_W + MV_W;
  localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int NUM_W  = SUM_W + STEP_W;
  localparam int DEN_W  = CNT_W + SPAN_W;
  localparam int MAG_W  = CUR_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVG_DEPTH);

  // Configuration
  logic [REST_CUR_W-1:0] rest_cur_q;
  logic [TIME_W-1:0]     rest_time_q;

  // Captured item
  logic [VOLT_W-1:0] volt_q;
  logic [CUR_W-1:0]  cur_q;
  logic [TIME_W-1:0] time_q;

  // Averaging state
  logic [IDX_W-1:0] widx_q;
  logic             full_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] n_q;
  logic [VOLT_W-1:0] ring_rdata;

  // Rest tracking
  logic              resting_q;
  logic [TIME_W-1:0] rest_start_q;
  logic              go_q;
  logic [PCT_W-1:0]  latch_pct_q;
  logic              latch_vld_q;

  // Curve search and divider
  logic [SEG_W-1:0]  seg_q;
  logic [SUM_W-1:0]  diff_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  dsr_q;
  logic [QUO_W-1:0]  quo_q;
  logic [QCNT_W-1:0] qcnt_q;
  logic [PCT_W-1:0]  raw_q;

  // Output register
  logic              out_vld_q;
  logic [VOLT_W-1:0] out_volt_q;
  logic [CUR_W-1:0]  out_cur_q;
  logic [PCT_W-1:0]  out_raw_q;
  logic [PCT_W-1:0]  out_stable_q;
  logic              out_svld_q;

  // Ring update terms
  logic              wrap;
  logic [IDX_W-1:0]  widx_nx;
  logic              full_nx;
  logic [CNT_W-1:0]  n_nx;
  logic [SUM_W-1:0]  sum_nx;
  logic [VOLT_W-1:0] ring_old;

  // Rest terms
  logic [MAG_W-1:0]  mag;
  logic              is_rest;
  logic [TIME_W-1:0] start_eff;
  logic [TIME_W-1:0] elapsed;

  // Search and divide terms
  curve_pt_t         pt;
  logic [PROD_W-1:0] prod;
  logic              hit;
  logic              ge;
  logic [QUO_W-1:0]  quo_nx;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_cur_q  <= REST_CUR_RST;
      rest_time_q <= REST_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REST_CURRENT: rest_cur_q  <= cfg_data_i[REST_CUR_W-1:0];
        CFG_REST_TIME:    rest_time_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample ring
  bce_ram #(
    .WIDTH (VOLT_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accum),
    .waddr_i (widx_q),
    .wdata_i (volt_q),
    .re_i    (cmd_i.ring_rd),
    .raddr_i (widx_q),
    .rdata_o (ring_rdata)
  );

  // Ring index, fill count and running sum
  always_comb begin
    wrap     = (widx_q == IDX_LAST);
    widx_nx  = wrap ? '0 : widx_q + IDX_W'(1);
    full_nx  = full_q | wrap;
    n_nx     = full_nx ? CNT_FULL : CNT_W'(widx_q) + CNT_W'(1);
    ring_old = full_q ? ring_rdata : '0;
    sum_nx   = sum_q - SUM_W'(ring_old) + SUM_W'(volt_q);
  end

  // Current magnitude and rest timing
  always_comb begin
    mag       = cur_q[CUR_W-1] ? (MAG_W'(1) << CUR_W) - MAG_W'(cur_q) : MAG_W'(cur_q);
    is_rest   = mag < MAG_W'(rest_cur_q);
    start_eff = resting_q ? rest_start_q : time_q;
    elapsed   = time_q - start_eff;
  end

  // Segment compare and one restoring divide step
  always_comb begin
    pt     = CURVE[seg_q];
    prod   = PROD_W'(n_q) * PROD_W'(pt.mv);
    hit    = CMP_W'(sum_q) >= CMP_W'(prod);
    ge     = rem_q >= dsr_q;
    quo_nx = {quo_q[QUO_W-2:0], ge};
  end

  assign sts_o.hit       = hit;
  assign sts_o.seg_first = (seg_q == '0);
  assign sts_o.seg_last  = (seg_q == SEG_LAST);
  assign sts_o.div_last  = (qcnt_q == QCNT_LAST);
  assign sts_o.out_busy  = out_vld_q & ~out_ready_i;

  // Persistent state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q       <= '0;
      full_q       <= 1'b0;
      sum_q        <= '0;
      resting_q    <= 1'b0;
      rest_start_q <= '0;
      latch_pct_q  <= '0;
      latch_vld_q  <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        widx_q    <= widx_nx;
        full_q    <= full_nx;
        sum_q     <= sum_nx;
        resting_q <= is_rest;
        if (is_rest && !resting_q) begin
          rest_start_q <= time_q;
        end
      end
      if (cmd_i.out_load) begin
        latch_vld_q <= latch_vld_q | go_q;
        if (go_q) begin
          latch_pct_q <= raw_q;
        end
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers of one item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      volt_q <= in_volt_i;
      cur_q  <= in_cur_i;
      time_q <= in_time_i;
    end
    if (cmd_i.accum) begin
      n_q   <= n_nx;
      go_q  <= is_rest & (elapsed >= rest_time_q);
      seg_q <= '0;
    end
    // walk the curve from the top until the average clears a point
    if (cmd_i.cmp) begin
      if (hit) begin
        diff_q <= SUM_W'(CMP_W'(sum_q) - CMP_W'(prod));
        if (seg_q == '0) begin
          raw_q <= pt.base10;
        end
      end else if (seg_q == SEG_LAST) begin
        raw_q <= '0;
      end else begin
        seg_q <= seg_q + SEG_W'(1);
      end
    end
    if (cmd_i.mul_num) begin
      rem_q  <= NUM_W'(diff_q) * NUM_W'(pt.step10);
      quo_q  <= '0;
      qcnt_q <= '0;
    end
    if (cmd_i.mul_den) begin
      dsr_q <= NUM_W'(DEN_W'(n_q) * DEN_W'(pt.span)) << (QUO_W - 1);
    end
    if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q  <= dsr_q >> 1;
      quo_q  <= quo_nx;
      qcnt_q <= qcnt_q + QCNT_W'(1);
      raw_q  <= pt.base10 + PCT_W'(quo_nx);
    end
    if (cmd_i.out_load) begin
      out_volt_q   <= volt_q;
      out_cur_q    <= cur_q;
      out_raw_q    <= raw_q;
      out_stable_q <= go_q ? raw_q : (latch_vld_q ? latch_pct_q : raw_q);
      out_svld_q   <= latch_vld_q | go_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_volt_o       = out_volt_q;
  assign out_cur_o        = out_cur_q;
  assign out_raw_o        = out_raw_q;
  assign out_stable_o     = out_stable_q;
  assign out_stable_vld_o = out_svld_q;

endmodule

@@ hdl/bce_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the battery charge estimator, bound to the top.
// Depends on battery_charge_estimator_top.
module bce_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [55:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  // raw charge never exceeds 100.0 percent
  a_raw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[40:31] <= 10'd1000)
    else $error("raw charge out of range");

  // before any latch, stable follows raw
  a_stable_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[50:41] == m_axis_tdata_o[40:31])
    else $error("stable charge differs from raw before a latch");

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item accepted while one is in work");

endmodule

bind battery_charge_estimator_top bce_chk u_bce_chk (.*);

@@ dv/battery_charge_estimator_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for battery_charge_estimator_top: a scoreboard class
// predicts every result item from the accepted samples; tasks drive the block.
// Depends on bce_pkg and the RTL of the block.
module battery_charge_estimator_top_test;
  import bce_pkg::*;

  localparam int AVG_LEN       = 20;
  localparam int ITEMS_PER_RUN = 285;
  localparam int RUN_COUNT     = 7;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_AFTER    = 700;
  localparam int HOLD_CYCLES   = 500;
  localparam int SETTLE_CYCLES = 40;

  // One expected result item
  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [CUR_W-1:0]  cur;
    logic [PCT_W-1:0]  raw;
    logic [PCT_W-1:0]  stable;
    logic              stable_ok;
  } soc_result_t;

  // Charge predictor and store of expected result items
  class soc_scoreboard;
    logic [REST_CUR_W-1:0] rest_thr;
    logic [TIME_W-1:0]     rest_len;
    logic [VOLT_W-1:0]     ring [AVG_LEN];
    int unsigned           wr_idx;
    bit                    full;
    logic [19:0]           sum;
    bit                    resting;
    logic [TIME_W-1:0]     rest_start;
    logic [PCT_W-1:0]      latched_pct;
    bit                    latched_ok;
    soc_result_t           expected [$];
    int                    failures;
    int                    checked;

    function new();
      rest_thr    = 15'd50;
      rest_len    = 32'd30000;
      foreach (ring[k]) ring[k] = '0;
      wr_idx      = 0;
      full        = 0;
      sum         = '0;
      resting     = 0;
      rest_start  = '0;
      latched_pct = '0;
      latched_ok  = 0;
      failures    = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_REST_CURRENT) rest_thr = value[REST_CUR_W-1:0];
      else if (idx == CFG_REST_TIME) rest_len = value;
    endfunction

    function longint unsigned knee_mv(int k);
      case (k)
        0:       return 12600;
        1:       return 12450;
        2:       return 12350;
        3:       return 12250;
        4:       return 12150;
        5:       return 12050;
        6:       return 11950;
        7:       return 11850;
        8:       return 11750;
        9:       return 11600;
        10:      return 11400;
        default: return 10500;
      endcase
    endfunction

    function longint unsigned knee_pct(int k);
      case (k)
        0:       return 100;
        1:       return 95;
        2:       return 90;
        3:       return 80;
        4:       return 70;
        5:       return 60;
        6:       return 50;
        7:       return 40;
        8:       return 30;
        9:       return 20;
        10:      return 10;
        default: return 0;
      endcase
    endfunction

    // Clamped, linearly interpolated charge for the average s / n, truncated
    function logic [PCT_W-1:0] curve_tenths(longint unsigned s, longint unsigned n);
      longint unsigned num;
      longint unsigned den;
      int k;
      if (s >= n * knee_mv(0)) return 10'd1000;
      if (s <= n * knee_mv(11)) return 10'd0;
      for (k = 0; k < 11; k++) begin
        if (s >= n * knee_mv(k + 1)) begin
          num = (s - n * knee_mv(k + 1)) * (knee_pct(k) - knee_pct(k + 1)) * 10;
          den = n * (knee_mv(k) - knee_mv(k + 1));
          return PCT_W'(knee_pct(k + 1) * 10 + num / den);
        end
      end
      return 10'd0;
    endfunction

    // Update the predicted state with one accepted sample
    function void note_sample(logic [VOLT_W-1:0] v, logic [CUR_W-1:0] c,
                              logic [TIME_W-1:0] t);
      soc_result_t r;
      int unsigned n;
      logic [16:0] mag;
      logic [PCT_W-1:0] raw;
      if (wr_idx >= AVG_LEN) wr_idx = 0;
      if (full) sum = sum - ring[wr_idx];
      ring[wr_idx] = v;
      sum = sum + v;
      wr_idx++;
      if (wr_idx >= AVG_LEN) begin
        wr_idx = 0;
        full = 1;
      end
      n = full ? AVG_LEN : wr_idx;
      if (n == 0) n = 1;
      raw = curve_tenths(longint'(sum), longint'(n));
      // Magnitude of the signed current; -32768 gives 32768
      mag = c[15] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
      if (mag < {2'b00, rest_thr}) begin
        if (!resting) begin
          resting = 1;
          rest_start = t;
        end
        if (TIME_W'(t - rest_start) >= rest_len) begin
          latched_pct = raw;
          latched_ok = 1;
        end
      end else begin
        resting = 0;
      end
      r.volt      = v;
      r.cur       = c;
      r.raw       = raw;
      r.stable    = latched_ok ? latched_pct : raw;
      r.stable_ok = latched_ok;
      expected.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      soc_result_t e;
      checked++;
      if (expected.size() == 0) begin
        $error("result item arrived with nothing expected");
        failures++;
        return;
      end
      e = expected.pop_front();
      if (d[14:0] !== e.volt) begin
        $error("voltage_out_mv: expected %0d, actual %0d", e.volt, d[14:0]);
        failures++;
      end
      if (d[30:15] !== e.cur) begin
        $error("current_out_ma: expected %0d, actual %0d", $signed(e.cur), $signed(d[30:15]));
        failures++;
      end
      if (d[40:31] !== e.raw) begin
        $error("percent_raw_tenths: expected %0d, actual %0d", e.raw, d[40:31]);
        failures++;
      end
      if (d[50:41] !== e.stable) begin
        $error("percent_stable_tenths: expected %0d, actual %0d", e.stable, d[50:41]);
        failures++;
      end
      if (u[0] !== e.stable_ok) begin
        $error("stable_valid: expected %0d, actual %0d", e.stable_ok, u[0]);
        failures++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_data;

  soc_scoreboard sb = new();

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  bit in_reset = 1;

  // Stimulus shaping state
  logic [REST_CUR_W-1:0] cur_thr = 15'd50;
  logic [TIME_W-1:0]     t_now;
  int                    v_base;
  bit                    rest_mode;

  battery_charge_estimator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni   = 1'b0;
    s_tdata  = '0;
    s_tvalid = 1'b0;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
  end

  // Receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted item
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (in_reset || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one sample and wait for it to be accepted
  task automatic send_sample(logic [VOLT_W-1:0] v, logic [CUR_W-1:0] c,
                             logic [TIME_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= {1'b0, t, c, v};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    sb.note_sample(v, c, t);
  endtask

  // Drain the block, then let it settle before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the scoreboard takes the new value after the enable drops
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    if (idx == CFG_REST_CURRENT) cur_thr = value[REST_CUR_W-1:0];
  endtask

  // Current in magnitude up to the rest threshold or from it upward, sometimes any pattern
  function automatic logic [CUR_W-1:0] pick_current(bit rest);
    int mag;
    if ($urandom_range(99) < 10) return CUR_W'($urandom);
    if (rest) mag = $urandom_range(int'(cur_thr), 0);
    else mag = $urandom_range(32768, int'(cur_thr));
    if (mag == 32768) return 16'h8000;
    if ($urandom_range(1) == 1) return CUR_W'(-mag);
    return CUR_W'(mag);
  endfunction

  // Voltage drifting around the curve, with outliers and extremes
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int sel;
    sel = $urandom_range(99);
    v_base = v_base + $urandom_range(80) - 40;
    if (v_base < 10300) v_base = 10300;
    if (v_base > 12800) v_base = 12800;
    if (sel < 8) return VOLT_W'($urandom);
    if (sel < 10) return ($urandom_range(1) == 1) ? 15'h7FFF : 15'h0000;
    return VOLT_W'(v_base + $urandom_range(60) - 30);
  endfunction

  task automatic random_run(int count);
    int sel;
    repeat (count) begin
      if ($urandom_range(99) < 8) rest_mode = !rest_mode;
      sel = $urandom_range(99);
      if (sel == 0) t_now = $urandom;
      else if (sel == 1) t_now = 32'hFFFF_FFFF - $urandom_range(6000);
      else t_now = t_now + $urandom_range(4000);
      send_sample(pick_voltage(), pick_current(rest_mode), t_now);
    end
  endtask

  // Main sequence
  initial begin
    int run;
    t_now = $urandom;
    v_base = 11900;
    rest_mode = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    in_reset = 0;

    // Directed: field extremes, clamps, curve knees, rest and latch, wrap
    send_sample(15'd0,     16'd0,      32'd0);           // rest from timestamp zero
    send_sample(15'h7FFF,  16'h7FFF,   32'd10);
    send_sample(15'd12600, 16'h8000,   32'd20);          // -32768 never rests
    send_sample(15'd10500, -16'sd49,   32'd100);         // rest starts
    send_sample(15'd12450, 16'd49,     32'd30099);       // one short of latch
    send_sample(15'd12350, 16'd0,      32'd30100);       // elapsed reaches rest time
    send_sample(15'd11400, 16'd50,     32'd30200);       // threshold ends rest, latch kept
    send_sample(15'd11600, -16'sd50,   32'd30300);
    send_sample(15'd12250, 16'd1,      32'hFFFF_FFF0);   // new rest near wrap
    send_sample(15'd12150, -16'sd1,    32'h0000_7520);   // elapsed wraps past zero
    send_sample(15'd12050, 16'h8000,   32'hFFFF_FFFF);
    send_sample(15'd11950, 16'h7FFF,   32'h5555_5555);
    send_sample(15'd11850, 16'd0,      32'hAAAA_AAAA);
    send_sample(15'd11750, 16'd0,      32'hAAAB_2000);
    send_sample(15'h5555,  16'h5555,   32'd0);
    send_sample(15'h2AAA,  16'hAAAA,   32'hFFFF_FFFF);
    repeat (6) send_sample(15'd12600, 16'd0, 32'd0);
    send_sample(15'd10499, 16'd0,      32'd1);
    send_sample(15'd12601, 16'd0,      32'd2);

    for (run = 0; run < RUN_COUNT; run++) begin
      drain();
      case (run)
        1: begin
          write_reg(CFG_REST_CURRENT, 32'd0);               // never rests
          write_reg(CFG_REST_TIME, 32'd1000);
        end
        2: begin
          write_reg(CFG_REST_CURRENT, 32'hFFFF_FFFF);       // masked to the maximum
          write_reg(CFG_REST_TIME, 32'd0);                  // latch on first rest
        end
        3: begin
          write_reg(CFG_REST_CURRENT, 32'd200);
          write_reg(CFG_REST_TIME, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(CFG_REST_CURRENT, 32'd1000);
          write_reg(CFG_REST_TIME, 32'd5000);
        end
        5: begin
          write_reg(CFG_REST_CURRENT, 32'($urandom_range(3000, 1)));
          write_reg(CFG_REST_TIME, 32'($urandom_range(60000)));
        end
        6: begin
          write_reg(CFG_REST_CURRENT, 32'd50);
          write_reg(CFG_REST_TIME, 32'd30000);
        end
        default: ;
      endcase
      case (run % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 68;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 68;
        end
        default: begin
          src_idle_pct = 28;
          sink_stall_pct = 28;
        end
      endcase
      random_run(ITEMS_PER_RUN);
    end

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
